### rtl/core/afc_pkg.sv
// ----------------------------------------------------------------------------
// Alpha fade controller package
// Phase and mode codes, field widths and constants shared by the fade core.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned DurationW = 16;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned AlphaW    = 8;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned DivSteps  = 8;

  localparam logic [AlphaW-1:0] FullAlpha = 8'hFF;

  typedef enum logic [PhaseW-1:0] {
    PH_OPAQUE = 2'd0,
    PH_CLEAR  = 2'd1,
    PH_FIN    = 2'd2,
    PH_FOUT   = 2'd3
  } phase_e;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK       = 2'd0,
    MODE_FADE_IN    = 2'd1,
    MODE_FADE_OUT   = 2'd2,
    MODE_SET_STATUS = 2'd3
  } mode_e;

endpackage

### rtl/core/afc_if.sv
// ----------------------------------------------------------------------------
// Alpha fade controller channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface afc_req_if;
  import afc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ModeW-1:0]     mode;
  logic [DurationW-1:0] duration;
  logic                 target_status;
  logic [DelayW-1:0]    delay;

  modport source (output valid, mode, duration, target_status, delay, input ready);
  modport sink   (input valid, mode, duration, target_status, delay, output ready);
endinterface

interface afc_rsp_if;
  import afc_pkg::*;

  logic              valid;
  logic              ready;
  logic [AlphaW-1:0] alpha;
  logic              draw_overlay;
  logic              accepted;
  logic [PhaseW-1:0] phase;

  modport source (output valid, alpha, draw_overlay, accepted, phase, input ready);
  modport sink   (input valid, alpha, draw_overlay, accepted, phase, output ready);
endinterface

### rtl/core/alpha_fade_controller_core.sv
// ----------------------------------------------------------------------------
// Alpha fade controller core
// Overlay fade phase sequencer with a shared iterative ramp divider.
// ----------------------------------------------------------------------------
// Requests arrive on req_i: a tick, a start of fade in or fade out, or a set
// status command with an optional delay in ticks. Every request yields one
// response on rsp_o with the current alpha, the drawn flag for ticks, the
// start acceptance flag and the phase after the request.
// A tick in a fading phase runs the shared divider for count*255/length,
// one quotient bit per cycle, and waits in ST_DIV until it is done.
// Ticks in the opaque or clear phase and all other commands skip the
// divider and go from ST_IDLE straight to ST_OUT. The block handles one
// request at a time: req_i.ready is low from acceptance until the
// response has been taken. While the receiver holds rsp_o.ready low, the
// response stays stable and no new request is taken. Reset puts the block
// in the opaque phase with alpha at 255 and no pending status change.
// ----------------------------------------------------------------------------
module alpha_fade_controller_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  afc_req_if.sink   req_i,
  afc_rsp_if.source rsp_o
);
  import afc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                 state_q;
  phase_e                 phase_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [COUNT_WIDTH-1:0] len_q;
  logic                   dly_valid_q;
  logic [DelayW-1:0]      dly_cnt_q;
  logic                   pend_q;
  logic [AlphaW-1:0]      alpha_q;
  logic                   drawn_q;
  logic                   acc_q;
  logic                   fin_q;

  logic                   req_fire;
  logic                   rsp_fire;
  mode_e                  mode;
  phase_e                 ph_apply;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] len_eff;
  logic [COUNT_WIDTH-1:0] div_cnt;
  logic [COUNT_WIDTH-1:0] dur_len;
  logic                   ramp_end;
  logic                   div_start;
  logic                   div_done;
  logic [AlphaW-1:0]      div_quot;
  logic [AlphaW-1:0]      ramp_alpha;

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = (state_q == ST_OUT);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign mode        = mode_e'(req_i.mode);

  assign ph_apply = (dly_valid_q && dly_cnt_q == '0) ? phase_e'({1'b0, pend_q}) : phase_q;
  assign cnt_inc  = count_q + 1'b1;
  assign ramp_end = cnt_inc >= len_q;
  assign len_eff  = (len_q == '0) ? COUNT_WIDTH'(1) : len_q;
  assign div_cnt  = (cnt_inc > len_eff) ? len_eff : cnt_inc;
  assign dur_len  = (COUNT_WIDTH'(req_i.duration) == '0) ? COUNT_WIDTH'(1)
                                                         : COUNT_WIDTH'(req_i.duration);

  assign div_start = req_fire && (mode == MODE_TICK)
                     && (ph_apply == PH_FIN || ph_apply == PH_FOUT);

  afc_div #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .count_i  (div_cnt),
    .length_i (len_eff),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  assign ramp_alpha = fin_q ? (FullAlpha - div_quot) : div_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_OPAQUE;
      count_q     <= '0;
      len_q       <= '0;
      dly_valid_q <= 1'b0;
      dly_cnt_q   <= '0;
      pend_q      <= 1'b0;
      alpha_q     <= FullAlpha;
      drawn_q     <= 1'b0;
      acc_q       <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            drawn_q <= 1'b0;
            acc_q   <= 1'b0;
            state_q <= ST_OUT;
            unique case (mode)
              MODE_TICK: begin
                if (dly_valid_q) begin
                  if (dly_cnt_q == '0) begin
                    dly_valid_q <= 1'b0;
                  end else begin
                    dly_cnt_q <= dly_cnt_q - 1'b1;
                  end
                end
                unique case (ph_apply) inside
                  PH_CLEAR: begin
                    phase_q <= PH_CLEAR;
                  end
                  PH_OPAQUE: begin
                    phase_q <= PH_OPAQUE;
                    alpha_q <= FullAlpha;
                    drawn_q <= 1'b1;
                  end
                  PH_FIN, PH_FOUT: begin
                    count_q <= cnt_inc;
                    fin_q   <= (ph_apply == PH_FIN);
                    state_q <= ST_DIV;
                    if (ramp_end) begin
                      phase_q <= (ph_apply == PH_FIN) ? PH_CLEAR : PH_OPAQUE;
                    end else begin
                      phase_q <= ph_apply;
                    end
                  end
                  default: begin
                    phase_q <= ph_apply;
                  end
                endcase
              end
              MODE_FADE_IN: begin
                if (phase_q == PH_OPAQUE) begin
                  phase_q <= PH_FIN;
                  count_q <= '0;
                  len_q   <= dur_len;
                  acc_q   <= 1'b1;
                end
              end
              MODE_FADE_OUT: begin
                if (phase_q == PH_CLEAR) begin
                  phase_q <= PH_FOUT;
                  count_q <= '0;
                  len_q   <= dur_len;
                  acc_q   <= 1'b1;
                end
              end
              MODE_SET_STATUS: begin
                pend_q      <= req_i.target_status;
                dly_valid_q <= 1'b1;
                if (req_i.delay != '0) begin
                  dly_cnt_q <= req_i.delay;
                end else begin
                  dly_cnt_q <= '0;
                  phase_q   <= phase_e'({1'b0, req_i.target_status});
                end
              end
              default: begin
                state_q <= ST_OUT;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            alpha_q <= ramp_alpha;
            drawn_q <= (ramp_alpha != '0);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (rsp_fire) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.alpha        = alpha_q;
  assign rsp_o.draw_overlay = drawn_q;
  assign rsp_o.accepted     = acc_q;
  assign rsp_o.phase        = phase_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("response pending while a new request is accepted");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_ramp_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIN || phase_q == PH_FOUT) |-> (len_q != '0 && count_q < len_q))
    else $error("fading phase with a finished or empty ramp");

  a_drawn_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.draw_overlay) |-> rsp_o.alpha != '0)
    else $error("overlay drawn with zero alpha");

endmodule

### rtl/core/afc_div.sv
// ----------------------------------------------------------------------------
// Alpha fade ramp divider
// Computes count*255/length one quotient bit per cycle by restoring division.
// ----------------------------------------------------------------------------
module afc_div #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COUNT_WIDTH-1:0]        count_i,
  input  logic [COUNT_WIDTH-1:0]        length_i,
  output logic                          done_o,
  output logic [afc_pkg::AlphaW-1:0]    quot_o
);
  import afc_pkg::*;

  localparam int unsigned StepW = $clog2(DivSteps);
  localparam int unsigned ProdW = COUNT_WIDTH + AlphaW;

  logic                   busy_q;
  logic                   done_q;
  logic [StepW-1:0]       step_q;
  logic [COUNT_WIDTH-1:0] rem_q;
  logic [COUNT_WIDTH-1:0] den_q;
  logic [AlphaW-1:0]      quot_q;

  logic [ProdW-1:0]       prod;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   diff;
  logic                   fits;

  // The product count*255 is formed as count*256 - count.
  assign prod  = {count_i, {AlphaW{1'b0}}} - {{AlphaW{1'b0}}, count_i};
  assign trial = {rem_q, quot_q[AlphaW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(DivSteps - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= prod[ProdW-1:AlphaW];
      quot_q <= prod[AlphaW-1:0];
      den_q  <= length_i;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      quot_q <= {quot_q[AlphaW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// Alpha fade controller core testbench
// Drives tick, fade start and set status requests through the request
// channel with random gaps, and throttles the response channel with random
// stalls and one long hold-off. A built-in model of the fade phases, the
// ramp and the delayed status change predicts every response. Responses are
// then compared field by field, in order. A short directed table covers
// reset, rejected starts, zero and maximum lengths and delays, and pending
// changes. A long random part follows, steered toward well-formed fades.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import afc_pkg::*;

  localparam int unsigned RandomItems = 1500;
  localparam int unsigned DirRows     = 27;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned CycleLimit  = 1000000;

  typedef struct packed {
    mode_e                mode;
    logic [DurationW-1:0] duration;
    logic                 target;
    logic [DelayW-1:0]    delay;
  } fade_req_t;

  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic              draw;
    logic              accepted;
    phase_e            phase;
  } fade_rsp_t;

  typedef struct packed {
    fade_req_t req;
    logic      typed;
    fade_rsp_t rsp;
  } fade_row_t;

  logic clk;
  logic rst_n;

  afc_req_if req_if ();
  afc_rsp_if rsp_if ();

  alpha_fade_controller_core u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  phase_e               fade_ph;
  logic [DurationW-1:0] step_cnt;
  logic [DurationW-1:0] fade_len;
  logic                 change_pending;
  logic [DelayW-1:0]    change_delay;
  phase_e               change_target;
  logic [AlphaW-1:0]    cur_alpha;

  fade_rsp_t   expected_rsp_q [$];
  fade_row_t   dir_tbl [DirRows];
  int unsigned n_errors;
  int unsigned n_checked;
  int unsigned n_ticks;
  int unsigned n_drawn;
  int unsigned n_starts;
  int unsigned n_taken;
  int unsigned n_status;
  int unsigned n_cycles;
  bit          calm;
  bit          hold_off_req;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding", n_cycles,
               expected_rsp_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic logic [AlphaW-1:0] fade_ramp_level();
    int unsigned eff_len;
    int unsigned cnt;
    eff_len = (fade_len != 0) ? fade_len : 1;
    cnt     = (step_cnt > eff_len) ? eff_len : step_cnt;
    return AlphaW'((cnt * FullAlpha) / eff_len);
  endfunction

  task automatic advance_fade(input fade_req_t r, output fade_rsp_t e);
    e = '0;
    case (r.mode)
      MODE_TICK: begin
        if (change_pending) begin
          if (change_delay == 0) begin
            fade_ph        = change_target;
            change_pending = 1'b0;
          end else begin
            change_delay = change_delay - 1'b1;
          end
        end
        if (fade_ph != PH_CLEAR) begin
          if (fade_ph == PH_OPAQUE) begin
            cur_alpha = FullAlpha;
          end else begin
            step_cnt  = step_cnt + 1'b1;
            cur_alpha = (fade_ph == PH_FIN) ? FullAlpha - fade_ramp_level()
                                            : fade_ramp_level();
            if (step_cnt >= fade_len) begin
              fade_ph = (fade_ph == PH_FIN) ? PH_CLEAR : PH_OPAQUE;
            end
          end
          e.draw = (cur_alpha != 0);
        end
      end
      MODE_FADE_IN, MODE_FADE_OUT: begin
        if ((r.mode == MODE_FADE_IN && fade_ph == PH_OPAQUE) ||
            (r.mode == MODE_FADE_OUT && fade_ph == PH_CLEAR)) begin
          fade_ph    = (r.mode == MODE_FADE_IN) ? PH_FIN : PH_FOUT;
          step_cnt   = '0;
          fade_len   = (r.duration != 0) ? r.duration : DurationW'(1);
          e.accepted = 1'b1;
        end
      end
      default: begin
        change_target  = r.target ? PH_CLEAR : PH_OPAQUE;
        change_pending = 1'b1;
        if (r.delay != 0) begin
          change_delay = r.delay;
        end else begin
          fade_ph      = change_target;
          change_delay = '0;
        end
      end
    endcase
    e.alpha = cur_alpha;
    e.phase = fade_ph;
  endtask

  // Starts from the matching settled phase are favored so that most fades
  // actually run; the rest is ticks, mismatched starts and status changes.
  task automatic draw_random_request(output fade_req_t r);
    int unsigned roll;
    roll       = $urandom_range(0, 99);
    r.target   = 1'($urandom);
    r.delay    = DelayW'($urandom);
    r.duration = DurationW'($urandom);
    if (fade_ph == PH_OPAQUE && roll < 25) begin
      r.mode = MODE_FADE_IN;
    end else if (fade_ph == PH_CLEAR && roll < 25) begin
      r.mode = MODE_FADE_OUT;
    end else if (roll < 33) begin
      r.mode = MODE_SET_STATUS;
    end else if (roll < 39) begin
      r.mode = mode_e'($urandom_range(1, 2));
    end else begin
      r.mode = MODE_TICK;
    end
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      r.duration = DurationW'($urandom_range(0, 12));
    end else if (roll < 95) begin
      r.duration = DurationW'($urandom_range(13, 60));
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      r.delay = '0;
    end else if (roll < 92) begin
      r.delay = DelayW'($urandom_range(1, 6));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_request(input fade_req_t r, input bit use_typed,
                               input fade_rsp_t typed_rsp);
    int unsigned roll;
    int unsigned gap;
    fade_rsp_t   pred;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= r.mode;
    req_if.duration      <= r.duration;
    req_if.target_status <= r.target;
    req_if.delay         <= r.delay;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    advance_fade(r, pred);
    expected_rsp_q.push_back(use_typed ? typed_rsp : pred);
    if (r.mode == MODE_TICK) begin
      n_ticks++;
      n_drawn += pred.draw;
    end else if (r.mode == MODE_SET_STATUS) begin
      n_status++;
    end else begin
      n_starts++;
      n_taken += pred.accepted;
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    fade_rsp_t e;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected response, alpha", rsp_if.alpha, 0);
      end else begin
        e = expected_rsp_q.pop_front();
        n_checked++;
        if (rsp_if.alpha !== e.alpha) report_mismatch("alpha", rsp_if.alpha, e.alpha);
        if (rsp_if.draw_overlay !== e.draw) begin
          report_mismatch("draw_overlay", rsp_if.draw_overlay, e.draw);
        end
        if (rsp_if.accepted !== e.accepted) begin
          report_mismatch("accepted", rsp_if.accepted, e.accepted);
        end
        if (rsp_if.phase !== e.phase) report_mismatch("phase", rsp_if.phase, e.phase);
      end
    end
  end

  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned roll;
    hold_left    = 0;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldCycles - 1;
        rsp_if.ready <= 1'b0;
      end else if (calm) begin
        rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          stall_left = $urandom_range(8, 40);
        end else if (roll < 25) begin
          stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin
    fade_req_t r;
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.mode          = MODE_TICK;
    req_if.duration      = '0;
    req_if.target_status = 1'b0;
    req_if.delay         = '0;
    calm                 = 1'b0;
    hold_off_req         = 1'b0;
    fade_ph              = PH_OPAQUE;
    step_cnt             = '0;
    fade_len             = '0;
    change_pending       = 1'b0;
    change_delay         = '0;
    change_target        = PH_OPAQUE;
    cur_alpha            = FullAlpha;

    dir_tbl[0]  = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b1,
                    '{8'hFF, 1'b1, 1'b0, PH_OPAQUE}};
    dir_tbl[1]  = '{'{MODE_FADE_OUT,   16'd5,     1'b0, 16'd0},     1'b1,
                    '{8'hFF, 1'b0, 1'b0, PH_OPAQUE}};
    dir_tbl[2]  = '{'{MODE_FADE_IN,    16'd0,     1'b0, 16'd0},     1'b1,
                    '{8'hFF, 1'b0, 1'b1, PH_FIN}};
    dir_tbl[3]  = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b1,
                    '{8'h00, 1'b0, 1'b0, PH_CLEAR}};
    dir_tbl[4]  = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b1,
                    '{8'h00, 1'b0, 1'b0, PH_CLEAR}};
    dir_tbl[5]  = '{'{MODE_FADE_IN,    16'd7,     1'b0, 16'd0},     1'b1,
                    '{8'h00, 1'b0, 1'b0, PH_CLEAR}};
    dir_tbl[6]  = '{'{MODE_FADE_OUT,   16'd3,     1'b0, 16'd0},     1'b1,
                    '{8'h00, 1'b0, 1'b1, PH_FOUT}};
    dir_tbl[7]  = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[8]  = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[9]  = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[10] = '{'{MODE_SET_STATUS, 16'd0,     1'b1, 16'd0},     1'b1,
                    '{8'hFF, 1'b0, 1'b0, PH_CLEAR}};
    dir_tbl[11] = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[12] = '{'{MODE_SET_STATUS, 16'd0,     1'b0, 16'd2},     1'b0, '0};
    dir_tbl[13] = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[14] = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[15] = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[16] = '{'{MODE_FADE_IN,    16'hFFFF,  1'b0, 16'd0},     1'b0, '0};
    dir_tbl[17] = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[18] = '{'{MODE_SET_STATUS, 16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[19] = '{'{MODE_FADE_IN,    16'd4,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[20] = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[21] = '{'{MODE_SET_STATUS, 16'd0,     1'b1, 16'hFFFF},  1'b0, '0};
    dir_tbl[22] = '{'{MODE_SET_STATUS, 16'd0,     1'b1, 16'd1},     1'b0, '0};
    dir_tbl[23] = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[24] = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};
    dir_tbl[25] = '{'{MODE_FADE_OUT,   16'hFFFF,  1'b0, 16'd0},     1'b0, '0};
    dir_tbl[26] = '{'{MODE_TICK,       16'd0,     1'b0, 16'd0},     1'b0, '0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirRows; i++) begin
      issue_request(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].rsp);
    end

    for (int i = 0; i < RandomItems; i++) begin
      calm = ((i / 100) % 5 == 1);
      if (i == 200) hold_off_req = 1'b1;
      draw_random_request(r);
      issue_request(r, 1'b0, '0);
    end
    req_if.valid <= 1'b0;
    calm = 1'b0;

    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d requests: %0d ticks with %0d drawn, %0d starts with %0d taken,",
             n_ticks + n_starts + n_status, n_ticks, n_drawn, n_starts, n_taken);
    $display("%0d status changes, %0d responses checked, %0d mismatches",
             n_status, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/afc_pkg.sv
rtl/core/afc_if.sv
rtl/core/afc_div.sv
rtl/core/alpha_fade_controller_core.sv
dv/tb_top.sv
